// ----- rtl/vce_pkg.sv -----
// ----------------------------------------------------------------------------
// vce_pkg
// Types and constants shared by the cosine elevation pipeline.
// ----------------------------------------------------------------------------
package vce_pkg;

  localparam int unsigned CompW   = 24;   // vector component width
  localparam int unsigned OutFrac = 30;   // fraction bits of the cosine
  localparam int unsigned DotW    = 50;   // signed dot product width
  localparam int unsigned NormW   = 48;   // squared length width
  localparam int unsigned ProdW   = 96;   // product of squared lengths
  localparam int unsigned RootW   = 48;   // square root width
  localparam int unsigned RemW    = 50;   // square root remainder width
  localparam int unsigned MagW    = 49;   // dot product magnitude width
  localparam int unsigned QW      = OutFrac + 1;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  typedef enum logic [CfgIdxW-1:0] {
    RegSunX = 2'd0,
    RegSunY = 2'd1,
    RegSunZ = 2'd2,
    RegNone = 2'd3
  } vce_reg_e;

  typedef struct packed {
    logic signed [CompW-1:0] up_x;
    logic signed [CompW-1:0] up_y;
    logic signed [CompW-1:0] up_z;
  } vce_in_t;

  typedef struct packed {
    logic signed [31:0] cosine;
    logic               status;
  } vce_out_t;

  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } vce_vec_t;

  // Square root stage payload.
  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [MagW-1:0]  mag;
    logic [ProdW-1:0] rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } vce_sq_t;

  // Division stage payload.
  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [RootW-1:0] d;
    logic [RootW-1:0] r;
    logic [QW-1:0]    q;
  } vce_dv_t;

endpackage

// ----- rtl/vector_cosine_elevation_top.sv -----
// ----------------------------------------------------------------------------
// vector_cosine_elevation_top
// Cosine of the angle between a surface up vector and a sun direction.
// ----------------------------------------------------------------------------
// Each request on the input channel carries one up vector in signed Q3.20.
// The block returns one result per request: the cosine of the angle to the
// sun vector held in three registers, as signed Q1.30 clamped to +-1.0, and
// a status bit that is set, with a cosine of zero, when either vector is all
// zero. The sun registers are written through the plain write port; the user
// must write them only while no request is in flight, which the block itself
// does not enforce. Writes to the unused index are ignored. The datapath is
// one fixed pipeline: four stages of products and sums, 48 square root
// stages that each settle one root bit, one stage for the integer quotient
// bit, 30 division stages that each settle one fraction bit, and the output
// register. That is 84 register stages. One request is accepted every cycle
// unless a held result stalls the pipeline.
// The whole pipeline moves together: when the output holds a result that the
// receiver stalls, every stage holds and the input stall is raised in the
// same cycle, so nothing is lost or repeated. Reset clears all valid bits and
// the sun registers; the pipeline then comes up empty.
// ----------------------------------------------------------------------------
module vector_cosine_elevation_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  vce_pkg::vce_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output vce_pkg::vce_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [vce_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [vce_pkg::CfgW-1:0]       cfg_wdata_i
);
  import vce_pkg::*;

  localparam int unsigned SqN  = RootW;
  localparam int unsigned DivN = OutFrac;

  logic     adv;
  vce_vec_t sun_q;

  // The pipeline advances unless a finished result is being held back.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sun_q <= '0;
    end else if (cfg_we_i) begin
      unique case (vce_reg_e'(cfg_idx_i))
        RegSunX: sun_q.x <= cfg_wdata_i;
        RegSunY: sun_q.y <= cfg_wdata_i;
        RegSunZ: sun_q.z <= cfg_wdata_i;
        RegNone: ;
        default: ;
      endcase
    end
  end

  // Products, sums and the radicand.
  logic    sq_vld [SqN+1];
  vce_sq_t sq_dat [SqN+1];

  vce_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_valid_i),
    .in_i   (in_data_i),
    .sun_i  (sun_q),
    .vld_o  (sq_vld[0]),
    .dat_o  (sq_dat[0])
  );

  // Square root of the product of squared lengths, one bit per stage.
  for (genvar g = 0; g < SqN; g++) begin : g_sqrt
    vce_sqrt_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (sq_vld[g]),
      .dat_i  (sq_dat[g]),
      .vld_o  (sq_vld[g+1]),
      .dat_o  (sq_dat[g+1])
    );
  end

  // Divisor setup and the integer quotient bit. The magnitude never exceeds
  // the divisor, so that bit settles with a single compare.
  vce_sq_t        sq_last;
  logic [RootW-1:0] dsr;
  logic           dv0_vld_q;
  vce_dv_t        dv0_q;

  assign sq_last = sq_dat[SqN];
  assign dsr     = (sq_last.root == '0) ? RootW'(1) : sq_last.root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_vld_q <= 1'b0;
    end else if (adv) begin
      dv0_vld_q <= sq_vld[SqN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv0_q.zero <= sq_last.zero;
      dv0_q.neg  <= sq_last.neg;
      dv0_q.d    <= dsr;
      if ({1'b0, sq_last.mag} >= {2'b00, dsr}) begin
        dv0_q.r <= RootW'({1'b0, sq_last.mag} - {2'b00, dsr});
        dv0_q.q <= QW'(1);
      end else begin
        dv0_q.r <= sq_last.mag[RootW-1:0];
        dv0_q.q <= '0;
      end
    end
  end

  // Fraction bits of the quotient, one per stage.
  logic    dv_vld [DivN+1];
  vce_dv_t dv_dat [DivN+1];

  assign dv_vld[0] = dv0_vld_q;
  assign dv_dat[0] = dv0_q;

  for (genvar g = 0; g < DivN; g++) begin : g_div
    vce_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (dv_vld[g]),
      .dat_i  (dv_dat[g]),
      .vld_o  (dv_vld[g+1]),
      .dat_o  (dv_dat[g+1])
    );
  end

  // Clamp, sign and the zero vector case, then the output register.
  vce_dv_t          dv_last;
  logic [QW-1:0]    uq;
  logic [31:0]      mag32;
  logic             out_vld_q;
  vce_out_t         out_q, out_d;

  assign dv_last = dv_dat[DivN];
  assign uq      = (dv_last.q > (QW'(1) << OutFrac)) ? (QW'(1) << OutFrac) : dv_last.q;
  assign mag32   = 32'(uq);

  always_comb begin
    out_d = '0;
    if (dv_last.zero) begin
      out_d.status = 1'b1;
    end else begin
      out_d.cosine = dv_last.neg ? -$signed(mag32) : $signed(mag32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld[DivN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // An invalid geometry result always carries a cosine of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.cosine == 32'sd0)
    else $error("status set with nonzero cosine");

  // The cosine never leaves the range of plus or minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cosine <= 32'sh4000_0000) &&
                    (out_data_o.cosine >= -32'sh4000_0000))
    else $error("cosine outside clamp range");

  // A held result freezes the whole pipeline, including the last stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(dv_vld[DivN]) && $stable(dv0_vld_q))
    else $error("pipeline moved while output was held");

  // Input stall is raised exactly when a valid result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not match output hold");

endmodule

// ----- rtl/vce_front.sv -----
// ----------------------------------------------------------------------------
// vce_front
// Four stages: products, sums, split product of lengths, radicand assembly.
// ----------------------------------------------------------------------------
module vce_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  vce_pkg::vce_in_t  in_i,
  input  vce_pkg::vce_vec_t sun_i,
  output logic            vld_o,
  output vce_pkg::vce_sq_t  dat_o
);
  import vce_pkg::*;

  logic [3:0] vld_q;

  // Stage 1: products.
  logic signed [2*CompW-1:0] px_q, py_q, pz_q;
  logic [2*CompW-2:0]        sx2_q, sy2_q, sz2_q, ux2_q, uy2_q, uz2_q;
  logic                      zero1_q;
  // Stage 2: sums.
  logic signed [DotW-1:0] dot_q;
  logic [NormW-1:0]       ns_q, nu_q;
  logic                   zero2_q;
  // Stage 3: partial products and magnitude.
  logic [2*CompW-1:0] pll_q, plh_q, phl_q, phh_q;
  logic [MagW-1:0]    mag3_q;
  logic               neg3_q, zero3_q;
  // Stage 4.
  vce_sq_t sq_q;

  logic signed [2*CompW-1:0] sx2_s, sy2_s, sz2_s, ux2_s, uy2_s, uz2_s;
  logic signed [DotW-1:0]    mag_s;
  logic [ProdW-1:0]          p_s;

  assign sx2_s = sun_i.x * sun_i.x;
  assign sy2_s = sun_i.y * sun_i.y;
  assign sz2_s = sun_i.z * sun_i.z;
  assign ux2_s = in_i.up_x * in_i.up_x;
  assign uy2_s = in_i.up_y * in_i.up_y;
  assign uz2_s = in_i.up_z * in_i.up_z;
  assign mag_s = dot_q[DotW-1] ? -dot_q : dot_q;
  assign p_s   = {{(ProdW-2*CompW){1'b0}}, pll_q}
               + ({{(ProdW-2*CompW){1'b0}}, plh_q} << CompW)
               + ({{(ProdW-2*CompW){1'b0}}, phl_q} << CompW)
               + ({{(ProdW-2*CompW){1'b0}}, phh_q} << (2*CompW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q    <= sun_i.x * in_i.up_x;
      py_q    <= sun_i.y * in_i.up_y;
      pz_q    <= sun_i.z * in_i.up_z;
      sx2_q   <= sx2_s[2*CompW-2:0];
      sy2_q   <= sy2_s[2*CompW-2:0];
      sz2_q   <= sz2_s[2*CompW-2:0];
      ux2_q   <= ux2_s[2*CompW-2:0];
      uy2_q   <= uy2_s[2*CompW-2:0];
      uz2_q   <= uz2_s[2*CompW-2:0];
      zero1_q <= (sun_i == '0) || (in_i == '0);

      dot_q   <= DotW'(px_q) + DotW'(py_q) + DotW'(pz_q);
      ns_q    <= NormW'(sx2_q) + NormW'(sy2_q) + NormW'(sz2_q);
      nu_q    <= NormW'(ux2_q) + NormW'(uy2_q) + NormW'(uz2_q);
      zero2_q <= zero1_q;

      pll_q   <= ns_q[CompW-1:0] * nu_q[CompW-1:0];
      plh_q   <= ns_q[CompW-1:0] * nu_q[NormW-1:CompW];
      phl_q   <= ns_q[NormW-1:CompW] * nu_q[CompW-1:0];
      phh_q   <= ns_q[NormW-1:CompW] * nu_q[NormW-1:CompW];
      mag3_q  <= mag_s[MagW-1:0];
      neg3_q  <= dot_q[DotW-1];
      zero3_q <= zero2_q;

      sq_q.zero <= zero3_q;
      sq_q.neg  <= neg3_q;
      sq_q.mag  <= mag3_q;
      sq_q.rad  <= p_s;
      sq_q.rem  <= '0;
      sq_q.root <= '0;
    end
  end

  assign vld_o = vld_q[3];
  assign dat_o = sq_q;

endmodule

// ----- rtl/vce_sqrt_stage.sv -----
// ----------------------------------------------------------------------------
// vce_sqrt_stage
// One restoring square root step: one root bit per stage.
// ----------------------------------------------------------------------------
module vce_sqrt_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  vce_pkg::vce_sq_t dat_i,
  output logic             vld_o,
  output vce_pkg::vce_sq_t dat_o
);
  import vce_pkg::*;

  logic            vld_q;
  vce_sq_t         dat_q, dat_d;
  logic [RemW+1:0] rem2, trial;

  always_comb begin
    rem2  = {dat_i.rem, dat_i.rad[ProdW-1 -: 2]};
    trial = {2'b00, dat_i.root, 2'b01};
    dat_d = dat_i;
    dat_d.rad = {dat_i.rad[ProdW-3:0], 2'b00};
    if (rem2 >= trial) begin
      dat_d.rem  = RemW'(rem2 - trial);
      dat_d.root = {dat_i.root[RootW-2:0], 1'b1};
    end else begin
      dat_d.rem  = rem2[RemW-1:0];
      dat_d.root = {dat_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

// ----- rtl/vce_div_stage.sv -----
// ----------------------------------------------------------------------------
// vce_div_stage
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module vce_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  vce_pkg::vce_dv_t dat_i,
  output logic             vld_o,
  output vce_pkg::vce_dv_t dat_o
);
  import vce_pkg::*;

  logic         vld_q;
  vce_dv_t      dat_q, dat_d;
  logic [RootW:0] r2;

  always_comb begin
    r2    = {dat_i.r, 1'b0};
    dat_d = dat_i;
    if (r2 >= {1'b0, dat_i.d}) begin
      dat_d.r = RootW'(r2 - {1'b0, dat_i.d});
      dat_d.q = {dat_i.q[QW-2:0], 1'b1};
    end else begin
      dat_d.r = r2[RootW-1:0];
      dat_d.q = {dat_i.q[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the cosine elevation pipeline.
// ----------------------------------------------------------------------------
// Up vectors are sent through the valid/stall input channel while a
// scoreboard predicts each cosine and status from the sun registers held
// here. Directed cases cover the extremes, the zero vectors, the parallel
// and opposite cases and the unused register index; random phases follow
// under several sun settings, most with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import vce_pkg::*;

  localparam int unsigned Latency  = 84;
  localparam int unsigned MaxCycle = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  vce_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  vce_out_t out_data;
  logic     cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;

  // Sun vector as the predictor sees it.
  logic signed [CompW-1:0] sun_x_q, sun_y_q, sun_z_q;

  vce_out_t cosine_queue[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned requests_sent;
  int unsigned cycles;
  bit          free_run;     // no random idling while set
  int unsigned hold_off;     // receiver stall length requested by a test

  vector_cosine_elevation_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Floor of the square root of a 96-bit value, one root bit at a time.
  function automatic logic [47:0] root_floor(logic [95:0] v);
    logic [47:0] r;
    logic [47:0] c;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (48'd1 << b);
      if ({48'd0, c} * {48'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // Expected result for one up vector under the current sun vector.
  function automatic vce_out_t cosine_of(vce_in_t up);
    vce_out_t res;
    logic signed [63:0] dot;
    logic [63:0]  ns, nu, mag, d;
    logic [127:0] quot;
    logic signed [63:0] sx, sy, sz, ux, uy, uz;
    sx = sun_x_q; sy = sun_y_q; sz = sun_z_q;
    ux = up.up_x; uy = up.up_y; uz = up.up_z;
    res = '0;
    if ((sx == 0 && sy == 0 && sz == 0) || (ux == 0 && uy == 0 && uz == 0)) begin
      res.status = 1'b1;
      return res;
    end
    dot = sx * ux + sy * uy + sz * uz;
    ns  = sx * sx + sy * sy + sz * sz;
    nu  = ux * ux + uy * uy + uz * uz;
    d   = root_floor({32'd0, ns} * {32'd0, nu});
    if (d == 0) d = 1;
    mag  = (dot < 0) ? -dot : dot;
    quot = ({64'd0, mag} << OutFrac) / {64'd0, d};
    if (quot > (128'd1 << OutFrac)) quot = 128'd1 << OutFrac;
    res.cosine = (dot < 0) ? -quot[31:0] : quot[31:0];
    return res;
  endfunction

  task automatic write_reg(vce_reg_e idx, logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      RegSunX: sun_x_q = value;
      RegSunY: sun_y_q = value;
      RegSunZ: sun_z_q = value;
      default: ;
    endcase
  endtask

  task automatic set_sun(logic [CfgW-1:0] x, logic [CfgW-1:0] y, logic [CfgW-1:0] z);
    write_reg(RegSunX, x);
    write_reg(RegSunY, y);
    write_reg(RegSunZ, z);
  endtask

  // Sends one request; the expectation is queued when it is accepted.
  // Valid stays high after acceptance until the next idle cycle or drain.
  task automatic send_up(logic [CompW-1:0] x, logic [CompW-1:0] y, logic [CompW-1:0] z);
    vce_in_t up;
    up.up_x = x; up.up_y = y; up.up_z = z;
    while (!free_run && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= up;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cosine_queue.push_back(cosine_of(up));
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cosine_queue.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
  endtask

  function automatic logic [CompW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(64)) - 32);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    set_sun(24'h100000, 24'h000000, 24'h000000);
    send_up(24'h100000, 24'h0, 24'h0);          // parallel
    send_up(24'hF00000, 24'h0, 24'h0);          // opposite
    send_up(24'h0, 24'h100000, 24'h0);          // orthogonal
    send_up(24'h0, 24'h0, 24'h0);               // zero up vector
    send_up(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_up(24'h800000, 24'h800000, 24'h800000);
    send_up(24'h000001, 24'h0, 24'h0);
    send_up(24'hFFFFFF, 24'hFFFFFF, 24'h000001);
    drain();
    set_sun(24'h800000, 24'h800000, 24'h800000);
    send_up(24'h800000, 24'h800000, 24'h800000);
    send_up(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_up(24'h7FFFFF, 24'h800000, 24'h000000);
    send_up(24'h000001, 24'h000001, 24'h000001);
    drain();
    // The unused index must leave the sun vector alone.
    write_reg(RegNone, 24'h123456);
    send_up(24'h000003, 24'h7FFFFF, 24'h800000);
    drain();
    set_sun(24'h0, 24'h0, 24'h0);               // zero sun vector
    send_up(24'h100000, 24'h200000, 24'h300000);
    send_up(24'h0, 24'h0, 24'h0);
    drain();
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_up(rand_comp(), rand_comp(), rand_comp());
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    free_run = 1'b1;
    for (int unsigned i = 0; i < 100; i++) begin
      send_up(24'($urandom()), 24'($urandom()), 24'($urandom()));
    end
    free_run = 1'b0;
    drain();
  endtask

  // Receiver: random stalls, with an optional long hold-off.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !free_run && ($urandom_range(99) < 18);
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    vce_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (cosine_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cosine=%0d status=%0b", $time,
                 out_data.cosine, out_data.status);
      end else begin
        want = cosine_queue.pop_front();
        if (want.cosine !== out_data.cosine) begin
          errors++;
          $display("%0t: cosine expected %0d actual %0d", $time, want.cosine,
                   out_data.cosine);
        end
        if (want.status !== out_data.status) begin
          errors++;
          $display("%0t: status expected %0b actual %0b", $time, want.status,
                   out_data.status);
        end
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > MaxCycle) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = RegSunX;
    cfg_wdata = '0;
    sun_x_q = '0; sun_y_q = '0; sun_z_q = '0;
    errors = 0; results_seen = 0; requests_sent = 0; cycles = 0;
    free_run = 1'b0; hold_off = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_sun(24'h7FFFFF, 24'h000000, 24'h800000);
    test_random(80);
    set_sun(24'($urandom()), 24'($urandom()), 24'($urandom()));
    free_run = 1'b1;
    test_random(60);
    free_run = 1'b0;
    set_sun(24'h000001, 24'hFFFFFF, 24'h000000);
    test_random(80);
    set_sun(24'($urandom()), 24'($urandom()), 24'($urandom()));
    test_backpressure();
    set_sun(24'h800000, 24'h7FFFFF, 24'h123456);
    test_random(80);

    if (cosine_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, cosine_queue.size());
    end
    $display("Sent %0d up vectors over eight sun settings, checked %0d results.",
             requests_sent, results_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vce_pkg.sv
rtl/vce_front.sv
rtl/vce_sqrt_stage.sv
rtl/vce_div_stage.sv
rtl/vector_cosine_elevation_top.sv
tb/sv/tb.sv
